FILE: hdl/irrt_pkg.sv
// Package for the I/O region reservation table.
// Holds the result status codes and the control struct that the table
// drives into every storage cell. No dependencies.
package irrt_pkg;

  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ENTRY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

  // Per-cycle command to the row of cells.
  typedef struct packed {
    logic cap;     // capture the compare flags against a new request
    logic insert;  // open a slot at the insert point and write the request
    logic rotate;  // move every entry one place toward the head
  } cell_ctl_t;

endpackage

FILE: hdl/irrt_cell.sv
// One storage cell of the reservation table: a region's start, end and tag.
// Compares itself against a request, and takes data from its neighbors on
// insert and rotate. Depends on irrt_pkg.
module irrt_cell #(
  parameter int ADDR_WIDTH = 32,
  parameter int TAG_WIDTH  = 8
) (
  input  logic                  clk,
  input  irrt_pkg::cell_ctl_t   ctl,
  input  logic                  occ,
  input  logic                  tail,
  input  logic                  prev_occ,
  input  logic                  prev_lt,
  input  logic [ADDR_WIDTH-1:0] q_start,
  input  logic [ADDR_WIDTH-1:0] q_end,
  input  logic [ADDR_WIDTH-1:0] new_start,
  input  logic [ADDR_WIDTH-1:0] new_end,
  input  logic [TAG_WIDTH-1:0]  new_tag,
  input  logic [ADDR_WIDTH-1:0] prev_start,
  input  logic [ADDR_WIDTH-1:0] prev_end,
  input  logic [TAG_WIDTH-1:0]  prev_tag,
  input  logic [ADDR_WIDTH-1:0] next_start,
  input  logic [ADDR_WIDTH-1:0] next_end,
  input  logic [TAG_WIDTH-1:0]  next_tag,
  input  logic [ADDR_WIDTH-1:0] head_start,
  input  logic [ADDR_WIDTH-1:0] head_end,
  input  logic [TAG_WIDTH-1:0]  head_tag,
  output logic [ADDR_WIDTH-1:0] ent_start,
  output logic [ADDR_WIDTH-1:0] ent_end,
  output logic [TAG_WIDTH-1:0]  ent_tag,
  output logic                  lt,
  output logic                  ovl
);
  import irrt_pkg::*;

  logic [ADDR_WIDTH-1:0] start_r;
  logic [ADDR_WIDTH-1:0] end_r;
  logic [TAG_WIDTH-1:0]  tag_r;
  logic                  lt_r;
  logic                  ovl_r;

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      lt_r  <= occ && (start_r < q_start);
      ovl_r <= occ && (start_r <= q_end) && (q_start <= end_r);
    end
    if (ctl.insert) begin
      // The insert point is the first cell whose start is not below the
      // request; every occupied cell from there on moves up by one.
      if (prev_lt && !lt_r) begin
        start_r <= new_start;
        end_r   <= new_end;
        tag_r   <= new_tag;
      end else if (prev_occ && !prev_lt) begin
        start_r <= prev_start;
        end_r   <= prev_end;
        tag_r   <= prev_tag;
      end
    end else if (ctl.rotate) begin
      if (tail) begin
        start_r <= head_start;
        end_r   <= head_end;
        tag_r   <= head_tag;
      end else begin
        start_r <= next_start;
        end_r   <= next_end;
        tag_r   <= next_tag;
      end
    end
  end

  assign ent_start = start_r;
  assign ent_end   = end_r;
  assign ent_tag   = tag_r;
  assign lt        = lt_r;
  assign ovl       = ovl_r;

endmodule

FILE: hdl/io_region_reservation_table.sv
// I/O region reservation table: keeps up to CAPACITY non-overlapping address
// regions sorted by start, each with an owner tag. Depends on irrt_pkg, irrt_cell.
//
// Input channel (in_valid/in_ready): a beat with in_cmd = 0 requests the region
// [in_start_addr, in_start_addr + in_length - 1] for in_owner_tag; in_cmd = 1
// lists the table. Result channel (out_valid/out_ready) carries out_status,
// the region fields and out_last.
// A request's result beat is loaded into the output register from S_RESOLVE:
// the compare flags of all cells are registered in the accept cycle, and the
// decision and the shift insert happen in S_RESOLVE once the output is free.
// A new request is taken only after the last one resolves. A list gives
// one beat per stored entry, one per cycle while the output register is free,
// by rotating the cell row toward the head; after N entries the row is back in
// order, so a list holds in_ready low until its last (or ST_EMPTY) beat is loaded.
// Results sit in one output register; the block accepts a new beat while a
// result still waits, and only stalls when it has a new result to write.
// Reset empties the table at once; no clearing pass is needed.
module io_region_reservation_table #(
  parameter int CAPACITY   = 64,
  parameter int ADDR_WIDTH = 32,
  parameter int TAG_WIDTH  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [ADDR_WIDTH-1:0]           in_start_addr,
  input  logic [ADDR_WIDTH-1:0]           in_length,
  input  logic [TAG_WIDTH-1:0]            in_owner_tag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [irrt_pkg::STATUS_W-1:0]   out_status,
  output logic [ADDR_WIDTH-1:0]           out_region_start,
  output logic [ADDR_WIDTH-1:0]           out_region_end,
  output logic [TAG_WIDTH-1:0]            out_region_tag,
  output logic                            out_last
);
  import irrt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_RESOLVE = 2'd1;
  localparam logic [1:0] S_LIST    = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [ADDR_WIDTH-1:0] q_start_r;
  logic [ADDR_WIDTH-1:0] q_end_r;
  logic [TAG_WIDTH-1:0]  q_tag_r;
  logic                  full_r;
  logic                  inval_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [ADDR_WIDTH-1:0] out_start_r;
  logic [ADDR_WIDTH-1:0] out_end_r;
  logic [TAG_WIDTH-1:0]  out_tag_r;
  logic                  out_last_r;

  logic                  out_load;
  logic [STATUS_W-1:0]   res_status;
  logic [ADDR_WIDTH-1:0] res_start;
  logic [ADDR_WIDTH-1:0] res_end;
  logic [TAG_WIDTH-1:0]  res_tag;
  logic                  res_last;

  logic                  accept;
  logic                  out_free;
  logic [ADDR_WIDTH:0]   sum;
  logic [ADDR_WIDTH-1:0] q_end;
  logic                  q_inval;
  logic                  any_ovl;
  cell_ctl_t             ctl;

  logic [ADDR_WIDTH-1:0] c_start [CAPACITY];
  logic [ADDR_WIDTH-1:0] c_end   [CAPACITY];
  logic [TAG_WIDTH-1:0]  c_tag   [CAPACITY];
  logic [CAPACITY-1:0]   c_lt;
  logic [CAPACITY-1:0]   c_ovl;
  logic [CAPACITY-1:0]   c_occ;
  logic [CAPACITY-1:0]   c_tail;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // End address with the carry kept: a carry means the region wraps.
  assign sum     = {1'b0, in_start_addr} + {1'b0, in_length} - {{ADDR_WIDTH{1'b0}}, 1'b1};
  assign q_end   = sum[ADDR_WIDTH-1:0];
  assign q_inval = (in_length == '0) || sum[ADDR_WIDTH];
  assign any_ovl = |c_ovl;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      localparam int NXT = (gi == CAPACITY - 1) ? 0 : gi + 1;
      localparam int PRV = (gi == 0) ? 0 : gi - 1;

      assign c_occ[gi]  = (CNT_W'(gi) < count_r);
      assign c_tail[gi] = (CNT_W'(gi + 1) == count_r);

      irrt_cell #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .TAG_WIDTH  (TAG_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (c_occ[gi]),
        .tail       (c_tail[gi]),
        .prev_occ   ((gi == 0) ? 1'b0 : c_occ[PRV]),
        .prev_lt    ((gi == 0) ? 1'b1 : c_lt[PRV]),
        .q_start    (in_start_addr),
        .q_end      (q_end),
        .new_start  (q_start_r),
        .new_end    (q_end_r),
        .new_tag    (q_tag_r),
        .prev_start (c_start[PRV]),
        .prev_end   (c_end[PRV]),
        .prev_tag   (c_tag[PRV]),
        .next_start (c_start[NXT]),
        .next_end   (c_end[NXT]),
        .next_tag   (c_tag[NXT]),
        .head_start (c_start[0]),
        .head_end   (c_end[0]),
        .head_tag   (c_tag[0]),
        .ent_start  (c_start[gi]),
        .ent_end    (c_end[gi]),
        .ent_tag    (c_tag[gi]),
        .lt         (c_lt[gi]),
        .ovl        (c_ovl[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    ctl           = '0;
    out_load      = 1'b0;
    res_status    = ST_OK;
    res_start     = q_start_r;
    res_end       = q_end_r;
    res_tag       = q_tag_r;
    res_last      = 1'b1;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd) begin
            state_nxt = S_LIST;
            idx_nxt   = '0;
          end else begin
            state_nxt = S_RESOLVE;
            ctl.cap   = 1'b1;
          end
        end
      end
      S_RESOLVE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (full_r) begin
            res_status = ST_FULL;
          end else if (inval_r) begin
            res_status = ST_INVALID;
          end else if (any_ovl) begin
            res_status = ST_OVERLAP;
          end else begin
            res_status = ST_OK;
            ctl.insert = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_load = 1'b1;
          if (count_r == '0) begin
            res_status = ST_EMPTY;
            res_start  = '0;
            res_end    = '0;
            res_tag    = '0;
            state_nxt  = S_IDLE;
          end else begin
            res_status = ST_ENTRY;
            res_start  = c_start[0];
            res_end    = c_end[0];
            res_tag    = c_tag[0];
            res_last   = (idx_r + 1'b1 == count_r);
            ctl.rotate = 1'b1;
            idx_nxt    = idx_r + 1'b1;
            if (res_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      q_start_r <= in_start_addr;
      q_end_r   <= q_end;
      q_tag_r   <= in_owner_tag;
      full_r    <= (count_r == CNT_W'(CAPACITY));
      inval_r   <= q_inval;
    end
    if (out_load) begin
      out_status_r <= res_status;
      out_start_r  <= res_start;
      out_end_r    <= res_end;
      out_tag_r    <= res_tag;
      out_last_r   <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_region_start = out_start_r;
  assign out_region_end   = out_end_r;
  assign out_region_tag   = out_tag_r;
  assign out_last         = out_last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.insert |-> (state_r == S_RESOLVE) && !full_r && !inval_r && !any_ovl)
    else $error("insert without a clean request");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.insert |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the table by one");

  a_list_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) && (count_r != '0) |-> idx_r < count_r)
    else $error("list index ran past the table");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench for io_region_reservation_table: feeds request and list beats,
// predicts each result beat from a behavioral copy of the region table and
// checks them in order. Depends on irrt_pkg and the block's RTL.
module tb;
  import irrt_pkg::*;

  localparam int   CAPACITY    = 64;
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_LIST    = 1'b1;
  localparam int   QUIET_TAIL  = 30;
  localparam int   RANDOM_BEATS = 230;

  typedef struct {
    logic        cmd;
    logic [31:0] start_addr;
    logic [31:0] length;
    logic [7:0]  tag;
    bit          drain;
  } req_beat_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [31:0]         lo;
    logic [31:0]         hi;
    logic [7:0]          tag;
    logic                last;
  } rsp_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic [31:0] in_start_addr = '0;
  logic [31:0] in_length = '0;
  logic [7:0] in_owner_tag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [31:0] out_region_start;
  logic [31:0] out_region_end;
  logic [7:0] out_region_tag;
  logic out_last;

  io_region_reservation_table i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_start_addr    (in_start_addr),
    .in_length        (in_length),
    .in_owner_tag     (in_owner_tag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_region_start (out_region_start),
    .out_region_end   (out_region_end),
    .out_region_tag   (out_region_tag),
    .out_last         (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  req_beat_t   stim_beats[$];
  rsp_beat_t   expected_beats[$];
  req_beat_t   cur_beat;

  // Behavioral copy of the region table.
  logic [31:0] rsv_lo[CAPACITY];
  logic [31:0] rsv_hi[CAPACITY];
  logic [7:0]  rsv_tag[CAPACITY];
  int          rsv_count = 0;

  int n_total = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int status_seen[8];
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic void queue_beat(logic cmd, logic [31:0] s, logic [31:0] l,
                                     logic [7:0] t, bit drain = 1'b0);
    stim_beats.push_back('{cmd, s, l, t, drain});
  endfunction

  // Applies one accepted beat to the table copy and queues the beats it yields.
  function automatic void table_apply(req_beat_t b);
    rsp_beat_t r;
    logic [31:0] e;
    int i;
    int pos;
    bit clash;
    e = b.start_addr + b.length - 32'd1;
    if (b.cmd == CMD_LIST) begin
      if (rsv_count == 0) begin
        r = '{ST_EMPTY, 32'd0, 32'd0, 8'd0, 1'b1};
        expected_beats.push_back(r);
      end else begin
        for (i = 0; i < rsv_count; i++) begin
          r = '{ST_ENTRY, rsv_lo[i], rsv_hi[i], rsv_tag[i], i == rsv_count - 1};
          expected_beats.push_back(r);
        end
      end
      return;
    end
    r = '{ST_OK, b.start_addr, e, b.tag, 1'b1};
    clash = 1'b0;
    for (i = 0; i < rsv_count; i++)
      if (rsv_lo[i] <= e && b.start_addr <= rsv_hi[i]) clash = 1'b1;
    if (rsv_count == CAPACITY) begin
      r.status = ST_FULL;
    end else if (b.length == 32'd0 || b.length - 32'd1 > ~b.start_addr) begin
      r.status = ST_INVALID;
    end else if (clash) begin
      r.status = ST_OVERLAP;
    end else begin
      pos = 0;
      while (pos < rsv_count && rsv_lo[pos] < b.start_addr) pos++;
      for (i = rsv_count; i > pos; i--) begin
        rsv_lo[i]  = rsv_lo[i-1];
        rsv_hi[i]  = rsv_hi[i-1];
        rsv_tag[i] = rsv_tag[i-1];
      end
      rsv_lo[pos]  = b.start_addr;
      rsv_hi[pos]  = e;
      rsv_tag[pos] = b.tag;
      rsv_count++;
    end
    expected_beats.push_back(r);
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      n_errors++;
    end
  endtask

  // Sender: offers queued beats, with random gaps outside the quiet stretches.
  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        table_apply(cur_beat);
        n_accepted++;
        next_valid = 1'b0;
        if (hold_left == 0 && stim_beats.size() > QUIET_TAIL && (n_accepted % 60) < 40 &&
            $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 12);
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_beats.size() != 0 &&
                     !(stim_beats[0].drain && expected_beats.size() != 0)) begin
          cur_beat = stim_beats.pop_front();
          next_valid = 1'b1;
          in_cmd        <= cur_beat.cmd;
          in_start_addr <= cur_beat.start_addr;
          in_length     <= cur_beat.length;
          in_owner_tag  <= cur_beat.tag;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: checks each result beat and stalls in random bursts, plus one long hold.
  always @(posedge clk) begin
    rsp_beat_t want;
    logic next_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        status_seen[out_status]++;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d start %h end %h", $time,
                   out_status, out_region_start, out_region_end);
          n_errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("status", want.status, out_status);
          check_field("region_start", want.lo, out_region_start);
          check_field("region_end", want.hi, out_region_end);
          check_field("region_tag", want.tag, out_region_tag);
          check_field("last", want.last, out_last);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!hold_done && n_accepted >= 60) begin
        hold_done = 1'b1;
        hold_left = 199;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (stim_beats.size() > QUIET_TAIL && (n_checked % 150) < 100 &&
                   $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ready <= next_ready;
    end
  end

  initial begin
    int k;
    int sel;
    int p;
    logic [31:0] s;
    logic [31:0] l;
    logic [7:0] t;
    logic [31:0] hist_lo[$];
    logic [31:0] hist_len[$];

    // Directed opening: empty list, zero length at address 0, edges of the space.
    queue_beat(CMD_LIST, 32'd0, 32'd0, 8'd0);
    queue_beat(CMD_REQUEST, 32'h0000_0000, 32'd0, 8'h5a);
    queue_beat(CMD_REQUEST, 32'h0000_0000, 32'd1, 8'h00);
    queue_beat(CMD_REQUEST, 32'h0000_0000, 32'd1, 8'h01);
    queue_beat(CMD_REQUEST, 32'hffff_ffff, 32'd1, 8'hff);
    queue_beat(CMD_REQUEST, 32'hffff_ffff, 32'd2, 8'h02);
    queue_beat(CMD_REQUEST, 32'h0000_0000, 32'hffff_ffff, 8'h03);
    queue_beat(CMD_REQUEST, 32'h0000_0001, 32'hffff_ffff, 8'h04);
    queue_beat(CMD_REQUEST, 32'h0000_1000, 32'h100, 8'h11);
    queue_beat(CMD_REQUEST, 32'h0000_10ff, 32'd1, 8'h12);
    queue_beat(CMD_REQUEST, 32'h0000_0f00, 32'h100, 8'h13);
    queue_beat(CMD_REQUEST, 32'h0000_1100, 32'h10, 8'h14);
    queue_beat(CMD_REQUEST, 32'h0000_0800, 32'h1000, 8'h15);
    queue_beat(CMD_REQUEST, 32'h0000_1050, 32'd4, 8'h16);
    queue_beat(CMD_LIST, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
    queue_beat(CMD_REQUEST, 32'h8000_0000, 32'h0001_0000, 8'h80, 1'b1);
    queue_beat(CMD_REQUEST, 32'h0000_0001, 32'd0, 8'hff);
    queue_beat(CMD_LIST, 32'd0, 32'd0, 8'd0);

    // Random part: mostly well-formed requests, some near earlier ones, some noise.
    for (k = 0; k < RANDOM_BEATS; k++) begin
      sel = $urandom_range(0, 99);
      t = $urandom_range(0, 255);
      if (hist_lo.size() == 0 && sel >= 55 && sel < 75) sel = 20;
      if (sel < 10) begin
        queue_beat(CMD_LIST, $urandom, $urandom, t, $urandom_range(0, 3) == 0);
      end else if (sel < 55) begin
        s = $urandom;
        l = $urandom_range(1, 1 << $urandom_range(0, 16));
        queue_beat(CMD_REQUEST, s, l, t);
        hist_lo.push_back(s);
        hist_len.push_back(l);
      end else if (sel < 75) begin
        p = $urandom_range(0, hist_lo.size() - 1);
        l = $urandom_range(1, 256);
        case ($urandom_range(0, 4))
          0: s = hist_lo[p] + hist_len[p];
          1: s = hist_lo[p] + hist_len[p] - 32'd1;
          2: s = hist_lo[p] - l;
          3: s = hist_lo[p] - l + 32'd1;
          default: begin
            s = hist_lo[p];
            l = hist_len[p];
          end
        endcase
        queue_beat(CMD_REQUEST, s, l, t);
        hist_lo.push_back(s);
        hist_len.push_back(l);
      end else if (sel < 88) begin
        queue_beat(CMD_REQUEST, $urandom, 32'd0, t);
      end else begin
        // Both high bits set, so the end runs past the top of the space unless both equal 32'h8000_0000.
        queue_beat(CMD_REQUEST, $urandom | 32'h8000_0000, $urandom | 32'h8000_0000, t);
      end
    end

    // With the table full, the full check must win over the range checks.
    queue_beat(CMD_REQUEST, 32'h0000_0000, 32'd0, 8'hff);
    queue_beat(CMD_REQUEST, 32'hffff_fff0, 32'h100, 8'h00);
    queue_beat(CMD_REQUEST, 32'h0000_2000, 32'd1, 8'h21);
    queue_beat(CMD_LIST, 32'd0, 32'd0, 8'd0);
    n_total = stim_beats.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (n_accepted == n_total);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Run summary: %0d beats sent, %0d result beats checked, %0d regions held.",
             n_accepted, n_checked, rsv_count);
    $display("Statuses seen: ok %0d, overlap %0d, full %0d, invalid %0d, listed %0d, empty %0d.",
             status_seen[ST_OK], status_seen[ST_OVERLAP], status_seen[ST_FULL],
             status_seen[ST_INVALID], status_seen[ST_ENTRY], status_seen[ST_EMPTY]);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results still expected.", expected_beats.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
hdl/irrt_pkg.sv
hdl/irrt_cell.sv
hdl/io_region_reservation_table.sv
test/tb.sv
